@@ hw/rtl/cmdwd_pkg.sv @@
// Shared types, constants and register codes of the CAN command watchdog.
package cmdwd_pkg;

    // Field widths.
    localparam int ID_W    = 11;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int LEN_W   = 4;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;

    // Default depth of the queue between the classifier and the executor.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_CONTROL_ID   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HEARTBEAT_ID = 3'd1;
    localparam logic [CIDX_W-1:0] REG_MAGIC        = 3'd2;
    localparam logic [CIDX_W-1:0] REG_OFF_CODE     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ON_CODE      = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TOGGLE_CODE  = 3'd5;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT      = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [ID_W-1:0]   RST_CONTROL_ID   = 11'd256;
    localparam logic [ID_W-1:0]   RST_HEARTBEAT_ID = 11'd257;
    localparam logic [BYTE_W-1:0] RST_MAGIC        = 8'd165;
    localparam logic [BYTE_W-1:0] RST_OFF_CODE     = 8'd0;
    localparam logic [BYTE_W-1:0] RST_ON_CODE      = 8'd1;
    localparam logic [BYTE_W-1:0] RST_TOGGLE_CODE  = 8'd2;
    localparam logic [TIME_W-1:0] RST_TIMEOUT      = 32'd500000;

    // Action decided by the classifier for one item.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_HEARTBEAT,
        ACT_OFF,
        ACT_ON,
        ACT_TOGGLE,
        ACT_INVALID,
        ACT_TICK
    } action_t;

    // Classified item as it travels through the queue.
    typedef struct packed {
        action_t                 action;
        logic [TIME_W-1:0]       now;
        logic [BYTE_W-1:0]       code;
    } op_t;

    // Configuration register set.
    typedef struct packed {
        logic [ID_W-1:0]   control_id;
        logic [ID_W-1:0]   heartbeat_id;
        logic [BYTE_W-1:0] magic;
        logic [BYTE_W-1:0] off_code;
        logic [BYTE_W-1:0] on_code;
        logic [BYTE_W-1:0] toggle_code;
        logic [TIME_W-1:0] timeout;
    } cfg_t;

endpackage

@@ hw/rtl/cmdwd_front.sv @@
// Front end: accepts input items and classifies them into executor actions.
module cmdwd_front (
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [cmdwd_pkg::TIME_W-1:0] now_us,
    input  logic [cmdwd_pkg::ID_W-1:0]   frame_id,
    input  logic                         is_extended,
    input  logic                         is_remote,
    input  logic [cmdwd_pkg::LEN_W-1:0]  data_length,
    input  logic [cmdwd_pkg::BYTE_W-1:0] first_byte,
    input  cmdwd_pkg::cfg_t              cfg,
    input  logic                         queue_full,
    output logic                         push,
    output cmdwd_pkg::op_t               push_op
);
    import cmdwd_pkg::*;

    action_t action;

    // Take an item whenever the queue has room.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Decide what the item does; the heartbeat identifier wins over the control one.
    always_comb
    begin
        action = ACT_NONE;
        if (operation)
        begin
            action = ACT_TICK;
        end
        else if (is_extended || is_remote || (data_length == '0))
        begin
            action = ACT_NONE;
        end
        else if (frame_id == cfg.heartbeat_id)
        begin
            action = (first_byte == cfg.magic) ? ACT_HEARTBEAT : ACT_NONE;
        end
        else if (frame_id == cfg.control_id)
        begin
            if (first_byte == cfg.off_code)
                action = ACT_OFF;
            else if (first_byte == cfg.on_code)
                action = ACT_ON;
            else if (first_byte == cfg.toggle_code)
                action = ACT_TOGGLE;
            else
                action = ACT_INVALID;
        end
    end

    assign push_op.action = action;
    assign push_op.now    = now_us;
    assign push_op.code   = first_byte;

endmodule

@@ hw/rtl/cmdwd_queue.sv @@
// Short queue of classified items between the front end and the executor.
module cmdwd_queue #(
    parameter int DEPTH = cmdwd_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cmdwd_pkg::op_t push_op,
    input  logic           pop,
    output cmdwd_pkg::op_t pop_op,
    output logic           full,
    output logic           empty
);
    import cmdwd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    op_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_QW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slot_reg[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

endmodule

@@ hw/rtl/cmdwd_exec.sv @@
// Executor: applies classified items to the watchdog state and presents the result.
module cmdwd_exec (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmdwd_pkg::cfg_t              cfg,
    input  logic                         queue_empty,
    input  cmdwd_pkg::op_t               pop_op,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         output_enabled,
    output logic                         watchdog_tripped,
    output logic [cmdwd_pkg::BYTE_W-1:0] last_command,
    output logic [cmdwd_pkg::CNT_W-1:0]  command_total,
    output logic [cmdwd_pkg::CNT_W-1:0]  invalid_total,
    output logic [cmdwd_pkg::CNT_W-1:0]  heartbeat_total,
    output logic [cmdwd_pkg::TIME_W-1:0] last_command_time,
    output logic                         heartbeat_seen,
    output logic [cmdwd_pkg::TIME_W-1:0] last_heartbeat_time
);
    import cmdwd_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic              enable_reg, enable_next;
    logic              trip_reg, trip_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic [CNT_W-1:0]  cmd_cnt_reg, cmd_cnt_next;
    logic [CNT_W-1:0]  inv_cnt_reg, inv_cnt_next;
    logic [CNT_W-1:0]  hb_cnt_reg, hb_cnt_next;
    logic [TIME_W-1:0] cmd_stamp_reg, cmd_stamp_next;
    logic              seen_reg, seen_next;
    logic [TIME_W-1:0] hb_stamp_reg, hb_stamp_next;
    logic [TIME_W-1:0] age;
    logic              expired;

    // The state itself is the result; it only moves once the previous result is taken.
    assign pop            = !queue_empty && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop || (out_valid_reg && out_stall);

    // Heartbeat age wraps with the microsecond timer.
    assign age     = pop_op.now - hb_stamp_reg;
    assign expired = !seen_reg || (age > cfg.timeout);

    always_comb
    begin
        enable_next    = enable_reg;
        trip_next      = trip_reg;
        code_next      = code_reg;
        cmd_cnt_next   = cmd_cnt_reg;
        inv_cnt_next   = inv_cnt_reg;
        hb_cnt_next    = hb_cnt_reg;
        cmd_stamp_next = cmd_stamp_reg;
        seen_next      = seen_reg;
        hb_stamp_next  = hb_stamp_reg;
        if (pop)
        begin
            case (pop_op.action)
                ACT_HEARTBEAT:
                begin
                    hb_stamp_next = pop_op.now;
                    seen_next     = 1'b1;
                    hb_cnt_next   = hb_cnt_reg + 1'b1;
                end
                ACT_OFF, ACT_ON, ACT_TOGGLE:
                begin
                    if (pop_op.action == ACT_OFF)
                        enable_next = 1'b0;
                    else if (pop_op.action == ACT_ON)
                        enable_next = 1'b1;
                    else
                        enable_next = !enable_reg;
                    code_next      = pop_op.code;
                    cmd_stamp_next = pop_op.now;
                    hb_stamp_next  = pop_op.now;
                    seen_next      = 1'b1;
                    cmd_cnt_next   = cmd_cnt_reg + 1'b1;
                    trip_next      = 1'b0;
                end
                ACT_INVALID:
                begin
                    inv_cnt_next = inv_cnt_reg + 1'b1;
                end
                ACT_TICK:
                begin
                    if (enable_reg && expired)
                    begin
                        enable_next = 1'b0;
                        trip_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
            trip_reg      <= 1'b0;
            code_reg      <= RST_OFF_CODE;
            cmd_cnt_reg   <= '0;
            inv_cnt_reg   <= '0;
            hb_cnt_reg    <= '0;
            cmd_stamp_reg <= '0;
            seen_reg      <= 1'b0;
            hb_stamp_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            enable_reg    <= enable_next;
            trip_reg      <= trip_next;
            code_reg      <= code_next;
            cmd_cnt_reg   <= cmd_cnt_next;
            inv_cnt_reg   <= inv_cnt_next;
            hb_cnt_reg    <= hb_cnt_next;
            cmd_stamp_reg <= cmd_stamp_next;
            seen_reg      <= seen_next;
            hb_stamp_reg  <= hb_stamp_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign output_enabled      = enable_reg;
    assign watchdog_tripped    = trip_reg;
    assign last_command        = code_reg;
    assign command_total       = cmd_cnt_reg;
    assign invalid_total       = inv_cnt_reg;
    assign heartbeat_total     = hb_cnt_reg;
    assign last_command_time   = cmd_stamp_reg;
    assign heartbeat_seen      = seen_reg;
    assign last_heartbeat_time = hb_stamp_reg;

endmodule

@@ hw/rtl/can_command_watchdog.sv @@
// Top level of the CAN command watchdog: configuration registers and the three stages.
// A result is registered in the executor once its item has passed through the queue.
// Throughput: one item per cycle while the result is not stalled, set by the state update in the executor.
// The queue holds QUEUE_DEPTH classified items, so input keeps flowing while a result waits, until the queue is full.
// Reset: asynchronous, active low; configuration returns to its defaults, all state clears.
// Configuration writes are always ready and take effect in the following cycle.
module can_command_watchdog #(
    parameter int QUEUE_DEPTH = cmdwd_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [cmdwd_pkg::TIME_W-1:0]  now_us,
    input  logic [cmdwd_pkg::ID_W-1:0]    frame_id,
    input  logic                          is_extended,
    input  logic                          is_remote,
    input  logic [cmdwd_pkg::LEN_W-1:0]   data_length,
    input  logic [cmdwd_pkg::BYTE_W-1:0]  first_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          output_enabled,
    output logic                          watchdog_tripped,
    output logic [cmdwd_pkg::BYTE_W-1:0]  last_command,
    output logic [cmdwd_pkg::CNT_W-1:0]   command_total,
    output logic [cmdwd_pkg::CNT_W-1:0]   invalid_total,
    output logic [cmdwd_pkg::CNT_W-1:0]   heartbeat_total,
    output logic [cmdwd_pkg::TIME_W-1:0]  last_command_time,
    output logic                          heartbeat_seen,
    output logic [cmdwd_pkg::TIME_W-1:0]  last_heartbeat_time,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cmdwd_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [cmdwd_pkg::CDATA_W-1:0] cfg_data
);
    import cmdwd_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    op_t  push_op;
    op_t  pop_op;

    // Configuration register file; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CONTROL_ID:   cfg_next.control_id   = cfg_data[ID_W-1:0];
                REG_HEARTBEAT_ID: cfg_next.heartbeat_id = cfg_data[ID_W-1:0];
                REG_MAGIC:        cfg_next.magic        = cfg_data[BYTE_W-1:0];
                REG_OFF_CODE:     cfg_next.off_code     = cfg_data[BYTE_W-1:0];
                REG_ON_CODE:      cfg_next.on_code      = cfg_data[BYTE_W-1:0];
                REG_TOGGLE_CODE:  cfg_next.toggle_code  = cfg_data[BYTE_W-1:0];
                REG_TIMEOUT:      cfg_next.timeout      = cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_id   <= RST_CONTROL_ID;
            cfg_reg.heartbeat_id <= RST_HEARTBEAT_ID;
            cfg_reg.magic        <= RST_MAGIC;
            cfg_reg.off_code     <= RST_OFF_CODE;
            cfg_reg.on_code      <= RST_ON_CODE;
            cfg_reg.toggle_code  <= RST_TOGGLE_CODE;
            cfg_reg.timeout      <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classifier.
    cmdwd_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .now_us      (now_us),
        .frame_id    (frame_id),
        .is_extended (is_extended),
        .is_remote   (is_remote),
        .data_length (data_length),
        .first_byte  (first_byte),
        .cfg         (cfg_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_op     (push_op)
    );

    // Decoupling queue.
    cmdwd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // State update and result.
    cmdwd_exec u_exec (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .queue_empty         (queue_empty),
        .pop_op              (pop_op),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .output_enabled      (output_enabled),
        .watchdog_tripped    (watchdog_tripped),
        .last_command        (last_command),
        .command_total       (command_total),
        .invalid_total       (invalid_total),
        .heartbeat_total     (heartbeat_total),
        .last_command_time   (last_command_time),
        .heartbeat_seen      (heartbeat_seen),
        .last_heartbeat_time (last_heartbeat_time)
    );

endmodule

@@ hw/rtl/cmdwd_checker.sv @@
// Port-level checker of the CAN command watchdog and its bind to the top level.
module cmdwd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         output_enabled,
    input logic                         watchdog_tripped,
    input logic [cmdwd_pkg::CNT_W-1:0]  command_total,
    input logic [cmdwd_pkg::CNT_W-1:0]  heartbeat_total,
    input logic                         heartbeat_seen
);
    import cmdwd_pkg::*;

    // A stalled result stays offered.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A trip always leaves the output disabled until a command arrives.
    a_trip_off: assert property (@(posedge clk) disable iff (!rst_n)
        !(watchdog_tripped && output_enabled))
        else $error("output enabled while watchdog tripped");

    // The command counter only ever steps by one.
    a_cmd_step: assert property (@(posedge clk) disable iff (!rst_n)
        command_total != $past(command_total) |->
            command_total == $past(command_total) + 1'b1)
        else $error("command count jumped");

    // Counted heartbeats imply a recorded heartbeat.
    a_hb_seen: assert property (@(posedge clk) disable iff (!rst_n)
        heartbeat_total != $past(heartbeat_total) |-> heartbeat_seen)
        else $error("heartbeat counted but not marked seen");

endmodule

bind can_command_watchdog cmdwd_checker u_cmdwd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .output_enabled   (output_enabled),
    .watchdog_tripped (watchdog_tripped),
    .command_total    (command_total),
    .heartbeat_total  (heartbeat_total),
    .heartbeat_seen   (heartbeat_seen)
);

@@ sim/can_command_watchdog_tb_pkg.sv @@
`timescale 1ns / 1ps
// Operation codes and the item layout shared by the watchdog testbench files.
package can_command_watchdog_tb_pkg;

    // Kind of item presented on the input channel.
    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } op_kind_t;

    // Index beyond the register list; a write to it must change nothing.
    localparam logic [cmdwd_pkg::CIDX_W-1:0] REG_UNUSED = 3'd7;

    // One input item as it is driven and observed.
    typedef struct packed {
        op_kind_t                     op;
        logic [cmdwd_pkg::TIME_W-1:0] now;
        logic [cmdwd_pkg::ID_W-1:0]   id;
        logic                         extended;
        logic                         remote;
        logic [cmdwd_pkg::LEN_W-1:0]  length;
        logic [cmdwd_pkg::BYTE_W-1:0] first;
    } can_item_t;

endpackage

@@ sim/can_command_watchdog_checker.sv @@
`timescale 1ns / 1ps
// Checker of the CAN command watchdog: tracks the expected state and compares every result.
module can_command_watchdog_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          operation,
    input  logic [cmdwd_pkg::TIME_W-1:0]  now_us,
    input  logic [cmdwd_pkg::ID_W-1:0]    frame_id,
    input  logic                          is_extended,
    input  logic                          is_remote,
    input  logic [cmdwd_pkg::LEN_W-1:0]   data_length,
    input  logic [cmdwd_pkg::BYTE_W-1:0]  first_byte,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          output_enabled,
    input  logic                          watchdog_tripped,
    input  logic [cmdwd_pkg::BYTE_W-1:0]  last_command,
    input  logic [cmdwd_pkg::CNT_W-1:0]   command_total,
    input  logic [cmdwd_pkg::CNT_W-1:0]   invalid_total,
    input  logic [cmdwd_pkg::CNT_W-1:0]   heartbeat_total,
    input  logic [cmdwd_pkg::TIME_W-1:0]  last_command_time,
    input  logic                          heartbeat_seen,
    input  logic [cmdwd_pkg::TIME_W-1:0]  last_heartbeat_time,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cmdwd_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [cmdwd_pkg::CDATA_W-1:0] cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import cmdwd_pkg::*;
    import can_command_watchdog_tb_pkg::*;

    // Watchdog state, which is also exactly what each result reports.
    typedef struct packed {
        logic              enabled;
        logic              tripped;
        logic [BYTE_W-1:0] command;
        logic [CNT_W-1:0]  commands;
        logic [CNT_W-1:0]  invalids;
        logic [CNT_W-1:0]  heartbeats;
        logic [TIME_W-1:0] command_time;
        logic              seen;
        logic [TIME_W-1:0] heartbeat_time;
    } wd_status_t;

    cfg_t       regs;
    wd_status_t tracked;
    wd_status_t due_status[$];
    int         mismatches = 0;

    // Applies one item to a copy of the watchdog state.
    function automatic wd_status_t advance_watchdog(input wd_status_t s, input cfg_t c,
                                                    input can_item_t it);
        logic [TIME_W-1:0] age;
        logic              known;
        age   = it.now - s.heartbeat_time;
        known = 1'b1;
        if (it.op == OP_TICK) begin
            if (s.enabled && (!s.seen || age > c.timeout)) begin
                s.enabled = 1'b0;
                s.tripped = 1'b1;
            end
        end else if (!it.extended && !it.remote && it.length != '0) begin
            if (it.id == c.heartbeat_id) begin
                // A heartbeat identifier takes precedence over a command identifier.
                if (it.first == c.magic) begin
                    s.heartbeat_time = it.now;
                    s.seen           = 1'b1;
                    s.heartbeats     = s.heartbeats + 1;
                end
            end else if (it.id == c.control_id) begin
                // Off beats on, and on beats toggle, when codes coincide.
                if (it.first == c.off_code)
                    s.enabled = 1'b0;
                else if (it.first == c.on_code)
                    s.enabled = 1'b1;
                else if (it.first == c.toggle_code)
                    s.enabled = !s.enabled;
                else
                    known = 1'b0;
                if (known) begin
                    s.command        = it.first;
                    s.command_time   = it.now;
                    s.heartbeat_time = it.now;
                    s.seen           = 1'b1;
                    s.commands       = s.commands + 1;
                    s.tripped        = 1'b0;
                end else begin
                    s.invalids = s.invalids + 1;
                end
            end
        end
        return s;
    endfunction

    // Reports one differing field and returns how many failures it adds.
    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want === got)
            return 0;
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        return 1;
    endfunction

    // Prediction on each accepted item, comparison on each accepted result.
    always @(posedge clk or negedge rst_n) begin : monitor
        can_item_t  item;
        wd_status_t got;
        wd_status_t want;
        if (!rst_n) begin
            regs = cfg_t'{control_id: RST_CONTROL_ID, heartbeat_id: RST_HEARTBEAT_ID,
                          magic: RST_MAGIC, off_code: RST_OFF_CODE, on_code: RST_ON_CODE,
                          toggle_code: RST_TOGGLE_CODE, timeout: RST_TIMEOUT};
            tracked = '0;
            tracked.command = RST_OFF_CODE;
            due_status.delete();
            fail_count <= mismatches;
            pending    <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                item = '{op: op_kind_t'(operation), now: now_us, id: frame_id,
                         extended: is_extended, remote: is_remote, length: data_length,
                         first: first_byte};
                tracked = advance_watchdog(tracked, regs, item);
                due_status.push_back(tracked);
            end

            if (out_valid && !out_stall) begin
                got = '{output_enabled, watchdog_tripped, last_command, command_total,
                        invalid_total, heartbeat_total, last_command_time, heartbeat_seen,
                        last_heartbeat_time};
                if (due_status.size() == 0) begin
                    $error("result delivered with no item outstanding");
                    mismatches++;
                end else begin
                    want = due_status.pop_front();
                    mismatches += field_mismatch("output_enabled", want.enabled, got.enabled);
                    mismatches += field_mismatch("watchdog_tripped", want.tripped, got.tripped);
                    mismatches += field_mismatch("last_command", want.command, got.command);
                    mismatches += field_mismatch("command_total", want.commands, got.commands);
                    mismatches += field_mismatch("invalid_total", want.invalids, got.invalids);
                    mismatches += field_mismatch("heartbeat_total", want.heartbeats,
                                                 got.heartbeats);
                    mismatches += field_mismatch("last_command_time", want.command_time,
                                                 got.command_time);
                    mismatches += field_mismatch("heartbeat_seen", want.seen, got.seen);
                    mismatches += field_mismatch("last_heartbeat_time", want.heartbeat_time,
                                                 got.heartbeat_time);
                end
            end

            // A register write only affects items taken after this edge.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CONTROL_ID:   regs.control_id   = cfg_data[ID_W-1:0];
                    REG_HEARTBEAT_ID: regs.heartbeat_id = cfg_data[ID_W-1:0];
                    REG_MAGIC:        regs.magic        = cfg_data[BYTE_W-1:0];
                    REG_OFF_CODE:     regs.off_code     = cfg_data[BYTE_W-1:0];
                    REG_ON_CODE:      regs.on_code      = cfg_data[BYTE_W-1:0];
                    REG_TOGGLE_CODE:  regs.toggle_code  = cfg_data[BYTE_W-1:0];
                    REG_TIMEOUT:      regs.timeout      = cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end

            fail_count <= mismatches;
            pending    <= due_status.size();
        end
    end

endmodule

@@ sim/can_command_watchdog_tb.sv @@
`timescale 1ns / 1ps
// Testbench top of the CAN command watchdog: clock, reset, stimulus and the verdict.
module can_command_watchdog_tb;
    import cmdwd_pkg::*;
    import can_command_watchdog_tb_pkg::*;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic                operation   = 1'b0;
    logic [TIME_W-1:0]   now_us      = '0;
    logic [ID_W-1:0]     frame_id    = '0;
    logic                is_extended = 1'b0;
    logic                is_remote   = 1'b0;
    logic [LEN_W-1:0]    data_length = '0;
    logic [BYTE_W-1:0]   first_byte  = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic                output_enabled;
    logic                watchdog_tripped;
    logic [BYTE_W-1:0]   last_command;
    logic [CNT_W-1:0]    command_total;
    logic [CNT_W-1:0]    invalid_total;
    logic [CNT_W-1:0]    heartbeat_total;
    logic [TIME_W-1:0]   last_command_time;
    logic                heartbeat_seen;
    logic [TIME_W-1:0]   last_heartbeat_time;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index   = '0;
    logic [CDATA_W-1:0]  cfg_data    = '0;
    int                  fail_count;
    int                  pending;

    // Idle rates of the two sides, in percent of cycles.
    int                  send_gap_pct  = 0;
    int                  out_stall_pct = 0;

    // Settings in force and the time base that the stimulus aims at.
    cfg_t                active_cfg;
    logic [TIME_W-1:0]   clock_us     = 32'd10000;
    logic [TIME_W-1:0]   last_refresh = 32'd10000;

    can_command_watchdog i_dut (.*);

    can_command_watchdog_checker i_checker (.*);

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Random back-pressure on the result side.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic can_item_t make_frame(input logic [TIME_W-1:0] at,
                                             input logic [ID_W-1:0] id,
                                             input logic [BYTE_W-1:0] payload,
                                             input logic [LEN_W-1:0] len);
        can_item_t it;
        it = '{op: OP_FRAME, now: at, id: id, extended: 1'b0, remote: 1'b0, length: len,
               first: payload};
        return it;
    endfunction

    // A tick carries junk in the frame fields, which it must ignore.
    function automatic can_item_t make_tick(input logic [TIME_W-1:0] at);
        can_item_t   it;
        logic [63:0] junk;
        junk   = {$urandom(), $urandom()};
        it     = junk[$bits(can_item_t)-1:0];
        it.op  = OP_TICK;
        it.now = at;
        return it;
    endfunction

    // Presents one item, with an optional gap first, and waits until it is taken.
    task automatic send_item(input can_item_t it);
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= it.op;
        now_us      <= it.now;
        frame_id    <= it.id;
        is_extended <= it.extended;
        is_remote   <= it.remote;
        data_length <= it.length;
        first_byte  <= it.first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Writes one register, with random data in the bits above its width.
    task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [CDATA_W-1:0] field,
                             input int bits);
        logic [CDATA_W-1:0] keep;
        keep = '1;
        if (bits < CDATA_W)
            keep = (32'd1 << bits) - 32'd1;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= ($urandom() & ~keep) | (field & keep);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes the whole register set, plus one write to an index that does not exist.
    task automatic program_regs(input cfg_t c);
        active_cfg = c;
        write_reg(REG_CONTROL_ID, c.control_id, ID_W);
        write_reg(REG_HEARTBEAT_ID, c.heartbeat_id, ID_W);
        write_reg(REG_MAGIC, c.magic, BYTE_W);
        write_reg(REG_OFF_CODE, c.off_code, BYTE_W);
        write_reg(REG_ON_CODE, c.on_code, BYTE_W);
        write_reg(REG_TOGGLE_CODE, c.toggle_code, BYTE_W);
        write_reg(REG_UNUSED, $urandom(), CDATA_W);
        write_reg(REG_TIMEOUT, c.timeout, TIME_W);
        cfg_valid <= 1'b0;
    endtask

    // Random settings, with shared identifiers and shared codes now and then.
    function automatic cfg_t random_cfg();
        cfg_t        c;
        logic [31:0] r;
        r = $urandom();
        c.control_id = r[ID_W-1:0];
        r = $urandom();
        c.heartbeat_id = ($urandom_range(7) == 0) ? c.control_id : r[ID_W-1:0];
        r = $urandom();
        c.magic    = r[7:0];
        c.off_code = r[15:8];
        c.on_code  = ($urandom_range(7) == 0) ? c.off_code : r[23:16];
        c.toggle_code = ($urandom_range(7) == 0) ? c.on_code : r[31:24];
        case ($urandom_range(3))
            0:       c.timeout = $urandom_range(2000);
            1:       c.timeout = $urandom();
            2:       c.timeout = '1;
            default: c.timeout = $urandom_range(1_000_000, 1);
        endcase
        return c;
    endfunction

    // Mostly well-formed commands, heartbeats and ticks, with some noise.
    task automatic run_random(input int count);
        can_item_t         it;
        logic [31:0]       r;
        int                pick;
        logic [BYTE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                clock_us = clock_us + $urandom();
            else
                clock_us = clock_us + $urandom_range(active_cfg.timeout >> 3);
            r    = ($urandom_range(3) == 0) ? $urandom_range(15, 1) : $urandom_range(8, 1);
            len  = r[LEN_W-1:0];
            r    = $urandom();
            pick = $urandom_range(99);
            if (pick < 25) begin
                // Half of the ticks land right at the edge of the timeout.
                if ($urandom_range(1) == 1)
                    clock_us = last_refresh + active_cfg.timeout + $urandom_range(2) - 32'd1;
                it = make_tick(clock_us);
            end else if (pick < 55) begin
                case ($urandom_range(4))
                    0:       code = active_cfg.off_code;
                    1, 2:    code = active_cfg.on_code;
                    default: code = active_cfg.toggle_code;
                endcase
                it = make_frame(clock_us, active_cfg.control_id, code, len);
                last_refresh = clock_us;
            end else if (pick < 70) begin
                it = make_frame(clock_us, active_cfg.heartbeat_id, active_cfg.magic, len);
                last_refresh = clock_us;
            end else if (pick < 77) begin
                it = make_frame(clock_us, active_cfg.heartbeat_id, r[7:0], len);
            end else if (pick < 85) begin
                it = make_frame(clock_us, active_cfg.control_id, r[7:0], len);
            end else begin
                it.op       = OP_FRAME;
                it.now      = clock_us;
                it.id       = r[ID_W-1:0];
                it.extended = r[11];
                it.remote   = r[12];
                it.length   = r[16:13];
                it.first    = r[24:17];
                if (r[25])
                    it.id = r[26] ? active_cfg.control_id : active_cfg.heartbeat_id;
            end
            send_item(it);
        end
    endtask

    initial begin
        can_item_t it;
        active_cfg = cfg_t'{control_id: RST_CONTROL_ID, heartbeat_id: RST_HEARTBEAT_ID,
                            magic: RST_MAGIC, off_code: RST_OFF_CODE, on_code: RST_ON_CODE,
                            toggle_code: RST_TOGGLE_CODE, timeout: RST_TIMEOUT};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct  = 28;
        out_stall_pct = 74;

        // Reset settings: enable at time zero, age at and past the limit, dropped frames.
        send_item(make_tick(32'd0));
        send_item(make_frame(32'd0, active_cfg.control_id, active_cfg.on_code, 4'd1));
        send_item(make_tick(active_cfg.timeout));
        send_item(make_tick(active_cfg.timeout + 32'd1));
        send_item(make_frame(32'hFFFF_FFFF, active_cfg.heartbeat_id, active_cfg.magic, 4'd15));
        send_item(make_frame(32'd40, active_cfg.heartbeat_id, ~active_cfg.magic, 4'd8));
        it = make_frame(32'd50, active_cfg.control_id, active_cfg.on_code, 4'd1);
        it.extended = 1'b1;
        send_item(it);
        it.extended = 1'b0;
        it.remote   = 1'b1;
        send_item(it);
        it.remote = 1'b0;
        it.length = '0;
        send_item(it);
        send_item(make_frame(32'd1000, active_cfg.control_id, active_cfg.toggle_code, 4'd8));
        send_item(make_frame(32'd1001, active_cfg.control_id, active_cfg.toggle_code, 4'd8));
        send_item(make_frame(32'd1002, active_cfg.control_id, 8'hFF, 4'd1));
        send_item(make_frame(32'd1003, 11'h7FF, active_cfg.on_code, 4'd1));
        // Enable just before the time wraps, then tick just after it.
        send_item(make_frame(32'hFFFF_FF00, active_cfg.control_id, active_cfg.on_code, 4'd2));
        send_item(make_tick(32'h0000_0010));
        send_item(make_frame(32'h20, active_cfg.control_id, active_cfg.off_code, 4'd3));

        // Zero timeout, and one code shared by on and toggle.
        drain();
        program_regs(cfg_t'{control_id: '1, heartbeat_id: '0, magic: '1, off_code: 8'h7F,
                            on_code: 8'h80, toggle_code: 8'h80, timeout: '0});
        send_item(make_frame(32'd5000, active_cfg.control_id, active_cfg.on_code, 4'd4));
        send_item(make_tick(32'd5000));
        send_item(make_tick(32'd5001));
        send_item(make_frame(32'd5002, active_cfg.heartbeat_id, active_cfg.magic, 4'd1));

        // One identifier for both heartbeats and commands.
        drain();
        program_regs(cfg_t'{control_id: 11'h155, heartbeat_id: 11'h155, magic: 8'h80,
                            off_code: 8'h80, on_code: 8'h80, toggle_code: 8'h80, timeout: '1});
        send_item(make_frame(32'd6000, 11'h155, 8'h80, 4'd2));
        send_item(make_frame(32'd6001, 11'h155, 8'h00, 4'd2));

        // Largest timeout, one code shared by off and on, heartbeat at time zero.
        drain();
        program_regs(cfg_t'{control_id: 11'h2AA, heartbeat_id: 11'h555, magic: 8'h00,
                            off_code: 8'h80, on_code: 8'h80, toggle_code: 8'h81, timeout: '1});
        send_item(make_frame(32'd7000, active_cfg.control_id, active_cfg.toggle_code, 4'd1));
        send_item(make_tick(32'h8000_0000));
        send_item(make_frame(32'd7002, active_cfg.control_id, active_cfg.off_code, 4'd1));
        send_item(make_frame(32'd0, active_cfg.heartbeat_id, active_cfg.magic, 4'd1));

        // Random part in three idling phases, with fresh settings every hundred items.
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct  = (phase == 0) ? 28 : (phase == 1) ? 74 : 0;
            out_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 28 : 0;
            repeat (4) begin
                drain();
                program_regs(random_cfg());
                run_random(100);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
